FILE: src/sbs_pkg.sv
// Shared types and constants of the strided block sampler.
package sbs_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned INDEX_W    = 48;
  localparam int unsigned EDGE_W     = 8;
  localparam int unsigned DIMS_W     = 2;
  localparam int unsigned OUT_DATA_W = WORD_W + INDEX_W;

  // Configuration port layout.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_COUNT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_EDGE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_STRIDE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_OUTER  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_MIDDLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_INNER  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [DIMS_W-1:0] DIM_COUNT_RST    = 2'd1;
  localparam logic [EDGE_W-1:0] BLOCK_EDGE_RST   = 8'd8;
  localparam logic [EDGE_W-1:0] BLOCK_STRIDE_RST = 8'd1;

  // Depth of the queue between the classifier and the output side.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Block geometry shared by all dimension slots.
  typedef struct packed {
    logic [DIMS_W-1:0] dim_count;
    logic [EDGE_W-1:0] block_edge;
    logic [EDGE_W-1:0] block_stride;
  } sbs_cfg_t;

  // One classified element on its way to the output side.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              keep;
    logic              vol_end;
  } sbs_item_t;

endpackage

FILE: src/strided_block_sampler.sv
// Top level of the strided block sampler: configuration registers and the datapath.
//
// The block takes a 1-, 2- or 3-D array as a raster-order stream of 32-bit words on
// s_axis, slowest dimension first, and tiles each active dimension into cubic blocks.
// Words of blocks that sit on the stride in every dimension and lie wholly inside the
// array leave on m_axis with their index in the sampled array; all others are dropped.
// After the last element of the volume every counter and the index restart at zero.
// Geometry is written through the cfg port (index 0 dimension count, 1 block edge,
// 2 stride, 3 to 5 the extents from outer to inner); write it only while idle.
// One element is taken every cycle while the stage can pass its element to the queue.
// The edge that accepts a request forms the block end products in the stage register;
// the element is then compared and queued, and a kept word is afterwards loaded into the
// output register that drives m_axis. A four-entry queue and the output register
// decouple the two sides; when the receiver stalls, the input keeps flowing until the
// queue is full, and s_axis_tready then follows the queue's free space.
// Reset loads the register defaults (one dimension, edge 8, stride 1, extents 1) and
// clears all counters; no clearing pass is needed.
module strided_block_sampler import sbs_pkg::*; #(
  parameter int unsigned EXTENT_BITS = 16,
  parameter int unsigned MAX_DIMS    = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [((EXTENT_BITS > 16) ? EXTENT_BITS : 16)-1:0] cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [WORD_W-1:0]      s_axis_tdata,   // [31:0] sample_word
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata    // [31:0] kept_word, [79:32] kept_index
);

  logic [DIMS_W-1:0]      dim_count_q;
  logic [EDGE_W-1:0]      block_edge_q;
  logic [EDGE_W-1:0]      block_stride_q;
  logic [EXTENT_BITS-1:0] extent_outer_q;
  logic [EXTENT_BITS-1:0] extent_middle_q;
  logic [EXTENT_BITS-1:0] extent_inner_q;
  logic [EXTENT_BITS-1:0] extent [MAX_DIMS];
  sbs_cfg_t               cfg;
  logic                   cfg_write;

  logic      q_push_valid;
  logic      q_push_ready;
  sbs_item_t q_push_item;
  logic      q_pop_valid;
  logic      q_pop_ready;
  sbs_item_t q_pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Register file; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q     <= DIM_COUNT_RST;
      block_edge_q    <= BLOCK_EDGE_RST;
      block_stride_q  <= BLOCK_STRIDE_RST;
      extent_outer_q  <= EXTENT_BITS'(1);
      extent_middle_q <= EXTENT_BITS'(1);
      extent_inner_q  <= EXTENT_BITS'(1);
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        REG_DIM_COUNT:     dim_count_q     <= cfg_data_i[DIMS_W-1:0];
        REG_BLOCK_EDGE:    block_edge_q    <= cfg_data_i[EDGE_W-1:0];
        REG_BLOCK_STRIDE:  block_stride_q  <= cfg_data_i[EDGE_W-1:0];
        REG_EXTENT_OUTER:  extent_outer_q  <= cfg_data_i[EXTENT_BITS-1:0];
        REG_EXTENT_MIDDLE: extent_middle_q <= cfg_data_i[EXTENT_BITS-1:0];
        REG_EXTENT_INNER:  extent_inner_q  <= cfg_data_i[EXTENT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.dim_count    = dim_count_q;
  assign cfg.block_edge   = block_edge_q;
  assign cfg.block_stride = block_stride_q;

  // Slot zero is the slowest dimension.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      case (d)
        0:       extent[d] = extent_outer_q;
        1:       extent[d] = extent_middle_q;
        default: extent[d] = extent_inner_q;
      endcase
    end
  end

  sbs_front #(
    .EXTENT_BITS (EXTENT_BITS),
    .MAX_DIMS    (MAX_DIMS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .extent_i     (extent),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_word_i    (s_axis_tdata),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_item_o  (q_push_item)
  );

  sbs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_item_i  (q_push_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_item_o   (q_pop_item)
  );

  sbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_item_i  (q_pop_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // The input only stalls when the queue has no room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> !q_push_ready)
    else $error("input stalled while the queue had room");

  // An element written to the queue is visible to the output side next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_valid && q_push_ready) |=> q_pop_valid)
    else $error("queue lost a written element");

  // A result only appears when the queue delivered one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((!m_axis_tvalid || m_axis_tready) && !(q_pop_valid && q_pop_ready))
      |=> !m_axis_tvalid)
    else $error("output valid without a queue read");

endmodule

FILE: src/sbs_front.sv
// Input side: position counters per dimension slot and the keep decision.
module sbs_front import sbs_pkg::*; #(
  parameter int unsigned EXTENT_BITS = 16,
  parameter int unsigned MAX_DIMS    = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sbs_cfg_t               cfg_i,
  input  logic [EXTENT_BITS-1:0] extent_i [MAX_DIMS],
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [WORD_W-1:0]      in_word_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output sbs_item_t              push_item_o
);

  localparam int unsigned PROD_W = EXTENT_BITS + 1 + EDGE_W;
  localparam logic [DIMS_W-1:0] MaxDimsL = DIMS_W'(MAX_DIMS);

  // Counter state per dimension slot.
  logic [EXTENT_BITS-1:0] pos_q   [MAX_DIMS];
  logic [EXTENT_BITS-1:0] pos_d   [MAX_DIMS];
  logic [EDGE_W-1:0]      off_q   [MAX_DIMS];
  logic [EDGE_W-1:0]      off_d   [MAX_DIMS];
  logic [EXTENT_BITS-1:0] blk_q   [MAX_DIMS];
  logic [EXTENT_BITS-1:0] blk_d   [MAX_DIMS];
  logic [EDGE_W-1:0]      phase_q [MAX_DIMS];
  logic [EDGE_W-1:0]      phase_d [MAX_DIMS];

  logic [EXTENT_BITS-1:0] ext_eff [MAX_DIMS];
  logic [EXTENT_BITS:0]   pos_inc [MAX_DIMS];
  logic [EXTENT_BITS:0]   blk_inc [MAX_DIMS];
  logic [MAX_DIMS-1:0]    hit_end;
  logic [MAX_DIMS-1:0]    carry;
  logic [MAX_DIMS-1:0]    active;
  logic                   carry_chain;
  logic [DIMS_W-1:0]      n_dims;
  logic [EDGE_W-1:0]      stride_eff;
  logic                   accept;

  // First pipeline stage: block end products and per-slot flags.
  logic                   s1_valid_q;
  logic [WORD_W-1:0]      s1_word_q;
  logic [PROD_W-1:0]      s1_prod_q [MAX_DIMS];
  logic [MAX_DIMS-1:0]    s1_phase_ok_q;
  logic [MAX_DIMS-1:0]    s1_active_q;
  logic                   s1_vol_end_q;
  logic                   s1_ready;
  logic [MAX_DIMS-1:0]    slot_ok;

  // Effective dimension count and stride.
  always_comb begin
    if (cfg_i.dim_count == '0) begin
      n_dims = DIMS_W'(1);
    end else if (cfg_i.dim_count > MaxDimsL) begin
      n_dims = MaxDimsL;
    end else begin
      n_dims = cfg_i.dim_count;
    end
    stride_eff = (cfg_i.block_stride == '0) ? EDGE_W'(1) : cfg_i.block_stride;
  end

  // Carry chain from the fastest active slot toward slot zero.
  always_comb begin
    carry_chain = 1'b0;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      ext_eff[d] = (extent_i[d] == '0) ? EXTENT_BITS'(1) : extent_i[d];
      pos_inc[d] = {1'b0, pos_q[d]} + (EXTENT_BITS + 1)'(1);
      blk_inc[d] = {1'b0, blk_q[d]} + (EXTENT_BITS + 1)'(1);
      hit_end[d] = pos_inc[d] >= {1'b0, ext_eff[d]};
      active[d]  = DIMS_W'(d) < n_dims;
      carry[d]   = active[d] && ((DIMS_W'(d) == n_dims - DIMS_W'(1)) || carry_chain);
      carry_chain = carry[d] && hit_end[d];
    end
  end

  // Next counter values for every slot that takes a carry.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      pos_d[d]   = pos_q[d];
      off_d[d]   = off_q[d];
      blk_d[d]   = blk_q[d];
      phase_d[d] = phase_q[d];
      if (carry[d]) begin
        if (hit_end[d]) begin
          pos_d[d]   = '0;
          off_d[d]   = '0;
          blk_d[d]   = '0;
          phase_d[d] = '0;
        end else begin
          pos_d[d] = pos_inc[d][EXTENT_BITS-1:0];
          if (({1'b0, off_q[d]} + 9'd1) >= {1'b0, cfg_i.block_edge}) begin
            off_d[d] = '0;
            blk_d[d] = blk_inc[d][EXTENT_BITS-1:0];
            if (({1'b0, phase_q[d]} + 9'd1) >= {1'b0, stride_eff}) begin
              phase_d[d] = '0;
            end else begin
              phase_d[d] = phase_q[d] + EDGE_W'(1);
            end
          end else begin
            off_d[d] = off_q[d] + EDGE_W'(1);
          end
        end
      end
    end
  end

  assign s1_ready   = !s1_valid_q || push_ready_i;
  assign in_ready_o = s1_ready;
  assign accept     = in_valid_i && s1_ready;

  // Counters advance once per accepted element.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        pos_q[d]   <= '0;
        off_q[d]   <= '0;
        blk_q[d]   <= '0;
        phase_q[d] <= '0;
      end
    end else if (accept) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        pos_q[d]   <= pos_d[d];
        off_q[d]   <= off_d[d];
        blk_q[d]   <= blk_d[d];
        phase_q[d] <= phase_d[d];
      end
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Stage payload: the end of each current block, computed before the compare.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q    <= in_word_i;
      s1_vol_end_q <= carry[0] && hit_end[0];
      s1_active_q  <= active;
      for (int d = 0; d < MAX_DIMS; d++) begin
        s1_prod_q[d]     <= PROD_W'(blk_inc[d]) * PROD_W'(cfg_i.block_edge);
        s1_phase_ok_q[d] <= (phase_q[d] == '0);
      end
    end
  end

  // A slot passes when it is inactive, or its block is on the stride and whole.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      slot_ok[d] = !s1_active_q[d] ||
                   (s1_phase_ok_q[d] && (s1_prod_q[d] <= PROD_W'(ext_eff[d])));
    end
  end

  assign push_valid_o         = s1_valid_q;
  assign push_item_o.word     = s1_word_q;
  assign push_item_o.keep     = (cfg_i.block_edge != '0) && (&slot_ok);
  assign push_item_o.vol_end  = s1_vol_end_q;

endmodule

FILE: src/sbs_fifo.sv
// Short register queue between the classifier and the output side.
module sbs_fifo import sbs_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  sbs_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output sbs_item_t pop_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  sbs_item_t         mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = count_q != FullCnt;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: src/sbs_back.sv
// Output side: running sample index and the output register.
module sbs_back import sbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  sbs_item_t             pop_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  logic [INDEX_W-1:0] count_q;
  logic [INDEX_W-1:0] count_d;
  logic               valid_q;
  logic               valid_d;
  logic [WORD_W-1:0]  word_q;
  logic [INDEX_W-1:0] index_q;
  logic               pop;
  logic               load;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign load        = pop && pop_item_i.keep;

  // Kept elements take the running count; the end of a volume restarts it.
  always_comb begin
    count_d = count_q;
    if (pop) begin
      if (pop_item_i.vol_end) begin
        count_d = '0;
      end else if (pop_item_i.keep) begin
        count_d = count_q + INDEX_W'(1);
      end
    end
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q  <= pop_item_i.word;
      index_q <= count_q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {index_q, word_q};

endmodule

FILE: test/sbs_stream_checker.sv
// Scoreboard for the strided block sampler: tracks geometry, predicts kept words, compares.
`timescale 1ns / 100ps

module sbs_stream_checker import sbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [WORD_W-1:0]      s_tdata_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_DATA_W-1:0]  m_tdata_i,
  output int unsigned            fails_o,
  output int unsigned            pending_o,
  output int unsigned            kept_o
);

  // One expected output request: the word and its index in the sampled array.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  word;
  } sampled_elem_t;

  // Shadow copy of the geometry registers.
  logic [DIMS_W-1:0] dim_cnt_q;
  logic [EDGE_W-1:0] blk_edge_q;
  logic [EDGE_W-1:0] stride_q;
  logic [15:0]       extent_q [0:2];

  // Raster walk state per dimension slot, slot 0 being the slowest.
  logic [15:0]        pos_q   [0:2];
  logic [7:0]         offs_q  [0:2];
  logic [15:0]        blk_q   [0:2];
  logic [7:0]         phase_q [0:2];
  logic [INDEX_W-1:0] index_ctr_q;

  sampled_elem_t awaited_q [$];
  int unsigned   fail_cnt;
  int unsigned   kept_cnt;

  // Scratch for the per-request work below.
  int unsigned   n_dims;
  int unsigned   d;
  logic          keep;
  logic [31:0]   blk_end;
  sampled_elem_t want;
  sampled_elem_t got;

  // A zero extent behaves as an extent of one.
  function automatic logic [31:0] axis_extent(input int unsigned slot);
    logic [31:0] e;
    e = 32'(extent_q[slot]);
    return (e == 0) ? 32'd1 : e;
  endfunction

  // Steps one slot forward; returns one when the slot wrapped and carries on.
  function automatic bit advance_axis(input int unsigned slot);
    logic [31:0] strd;
    strd = (stride_q == 0) ? 32'd1 : 32'(stride_q);
    if (32'(pos_q[slot]) + 32'd1 >= axis_extent(slot)) begin
      pos_q[slot]   = '0;
      offs_q[slot]  = '0;
      blk_q[slot]   = '0;
      phase_q[slot] = '0;
      return 1'b1;
    end
    pos_q[slot] = pos_q[slot] + 16'd1;
    if (32'(offs_q[slot]) + 32'd1 >= 32'(blk_edge_q)) begin
      offs_q[slot]  = '0;
      blk_q[slot]   = blk_q[slot] + 16'd1;
      phase_q[slot] = (32'(phase_q[slot]) + 32'd1 >= strd) ? 8'd0 : phase_q[slot] + 8'd1;
    end else begin
      offs_q[slot] = offs_q[slot] + 8'd1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_cnt_q   = DIM_COUNT_RST;
      blk_edge_q  = BLOCK_EDGE_RST;
      stride_q    = BLOCK_STRIDE_RST;
      index_ctr_q = '0;
      for (d = 0; d < 3; d++) begin
        extent_q[d] = 16'd1;
        pos_q[d]    = '0;
        offs_q[d]   = '0;
        blk_q[d]    = '0;
        phase_q[d]  = '0;
      end
      awaited_q.delete();
      fail_cnt  = 0;
      kept_cnt  = 0;
      fails_o   <= 0;
      pending_o <= 0;
      kept_o    <= 0;
    end else begin
      // Register writes update the shadow geometry, masked to each register's width.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DIM_COUNT:     dim_cnt_q   = cfg_data_i[DIMS_W-1:0];
          REG_BLOCK_EDGE:    blk_edge_q  = cfg_data_i[EDGE_W-1:0];
          REG_BLOCK_STRIDE:  stride_q    = cfg_data_i[EDGE_W-1:0];
          REG_EXTENT_OUTER:  extent_q[0] = cfg_data_i;
          REG_EXTENT_MIDDLE: extent_q[1] = cfg_data_i;
          REG_EXTENT_INNER:  extent_q[2] = cfg_data_i;
          default: ;
        endcase
      end

      // An accepted element is kept only if its block is on the stride and whole in
      // every active slot; then the walk advances from the fastest slot.
      if (s_tvalid_i && s_tready_i) begin
        n_dims = (dim_cnt_q == 0) ? 1 : int'(dim_cnt_q);
        keep   = (blk_edge_q != 0);
        for (d = 0; d < n_dims; d++) begin
          blk_end = (32'(blk_q[d]) + 32'd1) * 32'(blk_edge_q);
          if (phase_q[d] != 0 || blk_end > axis_extent(d)) keep = 1'b0;
        end
        if (keep) begin
          want.word  = s_tdata_i;
          want.index = index_ctr_q;
          awaited_q.push_back(want);
          index_ctr_q = index_ctr_q + 1'b1;
        end
        d = n_dims;
        while (d > 0) begin
          d = d - 1;
          if (!advance_axis(d)) break;
          // The slowest slot wrapping ends the volume.
          if (d == 0) index_ctr_q = '0;
        end
      end

      // Each output request is matched against the oldest expectation.
      if (m_tvalid_i && m_tready_i) begin
        got.word  = m_tdata_i[WORD_W-1:0];
        got.index = m_tdata_i[OUT_DATA_W-1:WORD_W];
        kept_cnt++;
        if (awaited_q.size() == 0) begin
          $error("unexpected output request: kept_word %h kept_index %0d",
                 got.word, got.index);
          fail_cnt++;
        end else begin
          want = awaited_q.pop_front();
          if (got.word !== want.word) begin
            $error("kept_word mismatch: expected %h, actual %h", want.word, got.word);
            fail_cnt++;
          end
          if (got.index !== want.index) begin
            $error("kept_index mismatch: expected %0d, actual %0d", want.index, got.index);
            fail_cnt++;
          end
        end
      end

      fails_o   <= fail_cnt;
      pending_o <= awaited_q.size();
      kept_o    <= kept_cnt;
    end
  end

endmodule

FILE: test/tb_strided_block_sampler.sv
// Testbench top for the strided block sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_strided_block_sampler import sbs_pkg::*; ();

  // Cycles a request may still spend inside the block after its input is taken.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned ITEMS_PER_MODE = 433;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]            cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [WORD_W-1:0]      s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  int unsigned fails;
  int unsigned pending;
  int unsigned kept;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_sent;
  int unsigned geometries;

  strided_block_sampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sbs_stream_checker scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fails_o     (fails),
    .pending_o   (pending),
    .kept_o      (kept)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver stalls at the rate of the current idle mode.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one sample word, with random gaps ahead of it, and waits for acceptance.
  task automatic push_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // Writes the whole geometry; unused upper data bits sometimes carry noise.
  task automatic set_geometry(input int unsigned dims, input int unsigned blen,
                              input int unsigned strd, input int unsigned e_outer,
                              input int unsigned e_middle, input int unsigned e_inner);
    logic [15:0] noise;
    noise = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'h0;
    write_reg(REG_DIM_COUNT, 16'(dims) | (noise & 16'hFFFC));
    write_reg(REG_BLOCK_EDGE, 16'(blen) | (noise & 16'hFF00));
    write_reg(REG_BLOCK_STRIDE, 16'(strd) | (noise & 16'hFF00));
    write_reg(REG_EXTENT_OUTER, 16'(e_outer));
    write_reg(REG_EXTENT_MIDDLE, 16'(e_middle));
    write_reg(REG_EXTENT_INNER, 16'(e_inner));
    cfg_valid <= 1'b0;
    geometries++;
  endtask

  // Stops the input and waits until the block has delivered and emptied its pipeline.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [WORD_W-1:0] corner [4];
    int unsigned       i;
    int unsigned       mode;
    int unsigned       kind;
    int unsigned       dims, blen, strd, e0, e1, e2, n;
    longint unsigned   vol;

    corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_DIM_COUNT;
    cfg_data      <= '0;
    send_idle_pct = 29;
    recv_idle_pct = 61;
    words_sent    = 0;
    geometries    = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: extent one against edge eight, so no block is ever whole.
    push_word(corner[0]);
    push_word(corner[1]);
    settle();

    // A 3x4 plane in 2x2 blocks: the last row is a partial block and is dropped.
    set_geometry(2, 2, 1, 3, 4, 7);
    for (i = 0; i < 12; i++) push_word(i < 4 ? corner[i] : $urandom());
    settle();

    // Zero edge keeps nothing; zero count, stride and extents act as one.
    set_geometry(0, 0, 0, 0, 0, 0);
    push_word(corner[2]);
    push_word(corner[3]);
    settle();
    set_geometry(0, 1, 0, 0, 0, 0);
    for (i = 0; i < 3; i++) push_word($urandom());
    settle();

    // Shrinking the extent mid-volume: the position past the new end wraps next.
    set_geometry(1, 1, 2, 5, 1, 1);
    for (i = 0; i < 3; i++) push_word($urandom());
    settle();
    set_geometry(1, 1, 2, 2, 1, 1);
    for (i = 0; i < 3; i++) push_word($urandom());
    settle();

    // Random geometries, often left mid-volume, under three idle patterns.
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 61 : 0;
      recv_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 29 : 0;
      while (words_sent < 25 + ITEMS_PER_MODE * (mode + 1)) begin
        kind = $urandom_range(0, 11);
        dims = $urandom_range(1, 3);
        blen = $urandom_range(1, 4);
        strd = $urandom_range(1, 3);
        e0   = $urandom_range(1, 8);
        e1   = $urandom_range(1, 8);
        e2   = $urandom_range(1, 6);
        case (kind)
          0: begin
            // Largest edge, stride and extents.
            blen = 255;
            strd = 255;
            e0   = 65535;
            e1   = 65535;
            e2   = 65535;
          end
          1: begin
            // Long 1-D line with single-element blocks on a wide stride.
            dims = 1;
            blen = 1;
            strd = 255;
            e0   = $urandom_range(256, 65535);
          end
          2: blen = 0;
          3: begin
            dims = 0;
            strd = 0;
            e1   = 0;
            e2   = 0;
            if ($urandom_range(0, 1) == 0) e0 = 0;
          end
          4: begin
            blen = 1;
            strd = 1;
          end
          default: ;
        endcase
        set_geometry(dims, blen, strd, e0, e1, e2);

        vol = (e0 == 0) ? 1 : e0;
        if (dims >= 2) vol = vol * ((e1 == 0) ? 1 : e1);
        if (dims == 3) vol = vol * ((e2 == 0) ? 1 : e2);
        n = (vol > 120) ? 121 : int'(vol) + $urandom_range(0, int'(vol));
        if (n > 120) n = $urandom_range(40, 120);
        for (i = 0; i < n; i++) push_word($urandom());
        settle();
      end
    end

    $display("Run sent %0d sample words through %0d geometry settings in 1-D, 2-D and 3-D,",
             words_sent, geometries);
    $display("and %0d kept words came back under three idle patterns.", kept);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
